>>> rtl/bbc_pkg.sv
// Shared types, codes and character decode for the bracket balance checker.
`timescale 1ns / 1ps

package bbc_pkg;

    localparam int MAX_DEPTH_DEF = 32;

    localparam int CHAR_W   = 8;
    localparam int LINE_W   = 24;
    localparam int STATUS_W = 3;
    localparam int OPEN_W   = 6;
    localparam int OUT_W    = STATUS_W + LINE_W + 2 * CHAR_W + OPEN_W;
    localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;

    localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};
    localparam logic [LINE_W-1:0] LINE_ONE = LINE_W'(1);
    localparam logic [OPEN_W-1:0] OPEN_MAX = {OPEN_W{1'b1}};

    localparam logic [CHAR_W-1:0] CH_LPAREN  = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN  = 8'h29;
    localparam logic [CHAR_W-1:0] CH_LSQUARE = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_RSQUARE = 8'h5D;
    localparam logic [CHAR_W-1:0] CH_LCURLY  = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_RCURLY  = 8'h7D;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NULL    = 8'h00;

    localparam logic OP_TEXT = 1'b0;
    localparam logic OP_EOF  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_SCAN          = 3'd0,
        ST_BALANCED      = 3'd1,
        ST_CLOSE_NO_OPEN = 3'd2,
        ST_MISMATCH      = 3'd3,
        ST_UNCLOSED      = 3'd4,
        ST_DEPTH         = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_ROUND  = 2'd1,
        KIND_SQUARE = 2'd2,
        KIND_CURLY  = 2'd3
    } kind_t;

    // Shift command broadcast along the stack chain.
    typedef struct packed {
        logic push;
        logic pop;
    } shift_t;

    function automatic kind_t open_kind(input logic [CHAR_W-1:0] ch);
        kind_t k;
        unique case (ch)
            CH_LPAREN:  k = KIND_ROUND;
            CH_LSQUARE: k = KIND_SQUARE;
            CH_LCURLY:  k = KIND_CURLY;
            default:    k = KIND_NONE;
        endcase
        return k;
    endfunction

    function automatic kind_t close_kind(input logic [CHAR_W-1:0] ch);
        kind_t k;
        unique case (ch)
            CH_RPAREN:  k = KIND_ROUND;
            CH_RSQUARE: k = KIND_SQUARE;
            CH_RCURLY:  k = KIND_CURLY;
            default:    k = KIND_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [CHAR_W-1:0] closer_of(input kind_t k);
        logic [CHAR_W-1:0] c;
        unique case (k)
            KIND_ROUND:  c = CH_RPAREN;
            KIND_SQUARE: c = CH_RSQUARE;
            KIND_CURLY:  c = CH_RCURLY;
            default:     c = CH_SPACE;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/bbc_cell.sv
// One stack entry: shifts down on push, up on pop.
`timescale 1ns / 1ps

module bbc_cell
(
    input  logic           clk,
    input  bbc_pkg::shift_t ctl,
    input  bbc_pkg::kind_t up_kind,    // from the entry above (or the new kind)
    input  bbc_pkg::kind_t down_kind,  // from the entry below
    output bbc_pkg::kind_t kind
);

    bbc_pkg::kind_t kind_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            kind_reg <= up_kind;
        end
        else if (ctl.pop)
        begin
            kind_reg <= down_kind;
        end
    end

    assign kind = kind_reg;

endmodule

>>> rtl/bracket_balance_checker.sv
// Bracket balance checker: one result item per input item, valid in the cycle
// after the item is taken; 1 item per cycle unless the output is held. The stack
// is a shift chain with its top at cell 0; push, pop and top compare finish per item.
// s_tready stays high while the output register is empty or being drained.
// rst_n (async, active low) clears depth, line counter, error and the output
// valid; stack cells hold no reset and are only read below the current depth.
`timescale 1ns / 1ps

module bracket_balance_checker
#(
    parameter int MAX_DEPTH = bbc_pkg::MAX_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,

    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [bbc_pkg::CHAR_W-1:0]  s_tdata,   // [7:0] char_in
    input  logic                        s_tuser,   // [0] op (0 text, 1 end of file)

    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [2:0] status, [26:3] line_no, [34:27] bad_char, [42:35] expected_char,
    // [48:43] open_count, [55:49] zero
    output logic [bbc_pkg::OUT_BYTES_W-1:0]  m_tdata
);

    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam logic [DW-1:0] DEPTH_FULL = DW'(MAX_DEPTH);

    // ---------------------------------------------------------------
    // Stack chain: cell 0 is the top of stack
    // ---------------------------------------------------------------
    bbc_pkg::kind_t  cell_kind [MAX_DEPTH];
    bbc_pkg::kind_t  push_kind;
    bbc_pkg::shift_t shift;

    for (genvar i = 0; i < MAX_DEPTH; i++)
    begin : g_cell
        bbc_pkg::kind_t up_k;
        bbc_pkg::kind_t down_k;

        if (i == 0)
        begin : g_top
            assign up_k = push_kind;
        end
        else
        begin : g_mid
            assign up_k = cell_kind[i-1];
        end

        if (i == MAX_DEPTH - 1)
        begin : g_bottom
            assign down_k = bbc_pkg::KIND_NONE;
        end
        else
        begin : g_inner
            assign down_k = cell_kind[i+1];
        end

        bbc_cell u_cell
        (
            .clk       (clk),
            .ctl       (shift),
            .up_kind   (up_k),
            .down_kind (down_k),
            .kind      (cell_kind[i])
        );
    end

    // ---------------------------------------------------------------
    // Scan state
    // ---------------------------------------------------------------
    logic [DW-1:0]                depth_reg,  depth_next;
    logic [bbc_pkg::LINE_W-1:0]   line_reg,   line_next;
    bbc_pkg::status_t             err_reg,    err_next;
    logic [bbc_pkg::LINE_W-1:0]   eline_reg,  eline_next;
    logic [bbc_pkg::CHAR_W-1:0]   ebad_reg,   ebad_next;
    logic [bbc_pkg::CHAR_W-1:0]   eexp_reg,   eexp_next;

    logic                         out_valid_reg;
    logic [bbc_pkg::OUT_W-1:0]    out_data_reg;
    logic [bbc_pkg::OUT_W-1:0]    out_data_next;

    logic                         s_acc;
    logic                         text_live;
    bbc_pkg::kind_t               ok_kind;
    bbc_pkg::kind_t               ck_kind;
    bbc_pkg::kind_t               top_kind;

    // depth after this item, before an end of file clears it
    logic [DW-1:0]                depth_scan;

    bbc_pkg::status_t             r_status;
    logic [bbc_pkg::LINE_W-1:0]   r_line;
    logic [bbc_pkg::CHAR_W-1:0]   r_bad;
    logic [bbc_pkg::CHAR_W-1:0]   r_exp;
    logic [bbc_pkg::OPEN_W-1:0]   r_open;

    assign s_tready = !out_valid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;
    assign ok_kind  = bbc_pkg::open_kind(s_tdata);
    assign ck_kind  = bbc_pkg::close_kind(s_tdata);
    assign top_kind = cell_kind[0];
    assign push_kind = ok_kind;

    assign text_live = s_acc && (s_tuser == bbc_pkg::OP_TEXT)
                       && (err_reg == bbc_pkg::ST_SCAN);

    // open_count saturates when the depth counter is wider than the field
    if (DW > bbc_pkg::OPEN_W)
    begin : g_open_sat
        assign r_open = (depth_scan > DW'(bbc_pkg::OPEN_MAX))
                        ? bbc_pkg::OPEN_MAX : depth_scan[bbc_pkg::OPEN_W-1:0];
    end
    else
    begin : g_open_ext
        assign r_open = bbc_pkg::OPEN_W'(depth_scan);
    end

    always_comb
    begin
        depth_next = depth_reg;
        line_next  = line_reg;
        err_next   = err_reg;
        eline_next = eline_reg;
        ebad_next  = ebad_reg;
        eexp_next  = eexp_reg;
        shift      = '0;

        if (text_live)
        begin
            if (ok_kind != bbc_pkg::KIND_NONE)
            begin
                if (depth_reg == DEPTH_FULL)
                begin
                    err_next   = bbc_pkg::ST_DEPTH;
                    eline_next = line_reg;
                    ebad_next  = s_tdata;
                    eexp_next  = bbc_pkg::CH_SPACE;
                end
                else
                begin
                    shift.push = 1'b1;
                    depth_next = depth_reg + DW'(1);
                end
            end
            else if (ck_kind != bbc_pkg::KIND_NONE)
            begin
                if (depth_reg == '0)
                begin
                    err_next   = bbc_pkg::ST_CLOSE_NO_OPEN;
                    eline_next = line_reg;
                    ebad_next  = s_tdata;
                    eexp_next  = bbc_pkg::CH_SPACE;
                end
                else if (top_kind != ck_kind)
                begin
                    err_next   = bbc_pkg::ST_MISMATCH;
                    eline_next = line_reg;
                    ebad_next  = s_tdata;
                    eexp_next  = bbc_pkg::closer_of(top_kind);
                end
                else
                begin
                    shift.pop  = 1'b1;
                    depth_next = depth_reg - DW'(1);
                end
            end
            else if (s_tdata == bbc_pkg::CH_NEWLINE && line_reg != bbc_pkg::LINE_MAX)
            begin
                line_next = line_reg + bbc_pkg::LINE_ONE;
            end
        end

        // result from the updated state
        if (err_next != bbc_pkg::ST_SCAN)
        begin
            r_status = err_next;
            r_line   = eline_next;
            r_bad    = ebad_next;
            r_exp    = eexp_next;
        end
        else
        begin
            if (s_tuser == bbc_pkg::OP_EOF)
            begin
                r_status = (depth_next == '0) ? bbc_pkg::ST_BALANCED
                                              : bbc_pkg::ST_UNCLOSED;
            end
            else
            begin
                r_status = bbc_pkg::ST_SCAN;
            end
            r_line = line_next;
            r_bad  = bbc_pkg::CH_NULL;
            r_exp  = bbc_pkg::CH_SPACE;
        end

        depth_scan = depth_next;

        // end of file: verdict above, then back to the reset state
        if (s_acc && s_tuser == bbc_pkg::OP_EOF)
        begin
            depth_next = '0;
            line_next  = bbc_pkg::LINE_ONE;
            err_next   = bbc_pkg::ST_SCAN;
            eline_next = bbc_pkg::LINE_ONE;
            ebad_next  = bbc_pkg::CH_NULL;
            eexp_next  = bbc_pkg::CH_SPACE;
        end
    end

    assign out_data_next = {r_open, r_exp, r_bad, r_line, r_status};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= '0;
            line_reg      <= bbc_pkg::LINE_ONE;
            err_reg       <= bbc_pkg::ST_SCAN;
            eline_reg     <= bbc_pkg::LINE_ONE;
            ebad_reg      <= bbc_pkg::CH_NULL;
            eexp_reg      <= bbc_pkg::CH_SPACE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_acc)
            begin
                depth_reg <= depth_next;
                line_reg  <= line_next;
                err_reg   <= err_next;
                eline_reg <= eline_next;
                ebad_reg  <= ebad_next;
                eexp_reg  <= eexp_next;
            end
            if (s_acc)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded with each accepted item
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = bbc_pkg::OUT_BYTES_W'(out_data_reg);

`ifndef SYNTHESIS
    // end of file leaves the scan state cleared
    a_eof_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && s_tuser == bbc_pkg::OP_EOF)
        |=> (depth_reg == '0 && err_reg == bbc_pkg::ST_SCAN
             && line_reg == bbc_pkg::LINE_ONE))
        else $error("scan state not cleared after end of file");

    // the depth counter never passes the stack size
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_FULL)
        else $error("stack depth beyond limit");

    // a held error freezes stack and line counter for text items
    a_sticky_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && s_tuser == bbc_pkg::OP_TEXT && err_reg != bbc_pkg::ST_SCAN)
        |=> ($stable(depth_reg) && $stable(line_reg) && $stable(err_reg)))
        else $error("state changed while an error was held");

    // push and pop never fire together
    a_shift_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(shift.push && shift.pop))
        else $error("push and pop in the same cycle");
`endif

endmodule

>>> verif/tb_top.sv
// Testbench for bracket_balance_checker: every result checked by predictor or table.
`timescale 1ns / 1ps

module tb_top;

    localparam int DEPTH = bbc_pkg::MAX_DEPTH_DEF;
    localparam int ITEMS = 1150;       // minimum items for the whole run, directed part included
    localparam int QUIET_TAIL = 150;   // last items run with no idling

    // Result item as it sits in m_tdata[48:0], lowest field last.
    typedef struct packed {
        logic [bbc_pkg::OPEN_W-1:0] open_cnt;
        logic [bbc_pkg::CHAR_W-1:0] expd;
        logic [bbc_pkg::CHAR_W-1:0] bad;
        logic [bbc_pkg::LINE_W-1:0] line;
        bbc_pkg::status_t           status;
    } scan_res_t;

    typedef struct {
        logic                       op;
        logic [bbc_pkg::CHAR_W-1:0] ch;
    } text_item_t;

    typedef struct {
        logic                       op;
        logic [bbc_pkg::CHAR_W-1:0] ch;
        int                         rep;     // item repeated this many times
        bit                         typed;   // last repeat checked against want
        scan_res_t                  want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [bbc_pkg::CHAR_W-1:0]      s_tdata = '0;
    logic                            s_tuser = bbc_pkg::OP_TEXT;

    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [bbc_pkg::OUT_BYTES_W-1:0] m_tdata;

    always #5 clk = ~clk;

    bracket_balance_checker dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Predictor state: bracket stack, line counter and the held first error.
    bbc_pkg::kind_t             open_stk [DEPTH];
    int unsigned                depth_now = 0;
    logic [bbc_pkg::LINE_W-1:0] line_now = bbc_pkg::LINE_ONE;
    bbc_pkg::status_t           err_st = bbc_pkg::ST_SCAN;
    logic [bbc_pkg::LINE_W-1:0] err_line = bbc_pkg::LINE_ONE;
    logic [bbc_pkg::CHAR_W-1:0] err_bad = bbc_pkg::CH_NULL;
    logic [bbc_pkg::CHAR_W-1:0] err_expd = bbc_pkg::CH_SPACE;

    scan_res_t  verdict_q [$];   // results still owed by the block
    text_item_t file_q [$];      // one generated file: text then end of file
    dir_row_t   dir_rows [$];

    int  err_count = 0;
    int  items_sent = 0;
    int  live_items = 0;
    int  files_sent = 0;
    int  results_seen = 0;
    int  status_seen [8];
    bit  quiet = 1'b0;
    bit  tx_idle_on = 1'b1;

    initial begin
        #5_000_000;
        $display("tb_top: errors");
        $finish;
    end

    function automatic logic [bbc_pkg::CHAR_W-1:0] opening_char(bbc_pkg::kind_t k);
        case (k)
            bbc_pkg::KIND_ROUND:  return bbc_pkg::CH_LPAREN;
            bbc_pkg::KIND_SQUARE: return bbc_pkg::CH_LSQUARE;
            default:              return bbc_pkg::CH_LCURLY;
        endcase
    endfunction

    function automatic logic [bbc_pkg::CHAR_W-1:0] closing_char(bbc_pkg::kind_t k);
        case (k)
            bbc_pkg::KIND_ROUND:  return bbc_pkg::CH_RPAREN;
            bbc_pkg::KIND_SQUARE: return bbc_pkg::CH_RSQUARE;
            bbc_pkg::KIND_CURLY:  return bbc_pkg::CH_RCURLY;
            default:              return bbc_pkg::CH_SPACE;
        endcase
    endfunction

    // Bracket kind of a byte, and whether it opens or closes.
    function automatic bbc_pkg::kind_t bracket_kind(input logic [bbc_pkg::CHAR_W-1:0] ch,
                                                    output bit is_open);
        bbc_pkg::kind_t k;
        k = bbc_pkg::KIND_NONE;
        is_open = 1'b0;
        case (ch)
            bbc_pkg::CH_LPAREN:  begin k = bbc_pkg::KIND_ROUND;  is_open = 1'b1; end
            bbc_pkg::CH_LSQUARE: begin k = bbc_pkg::KIND_SQUARE; is_open = 1'b1; end
            bbc_pkg::CH_LCURLY:  begin k = bbc_pkg::KIND_CURLY;  is_open = 1'b1; end
            bbc_pkg::CH_RPAREN:  k = bbc_pkg::KIND_ROUND;
            bbc_pkg::CH_RSQUARE: k = bbc_pkg::KIND_SQUARE;
            bbc_pkg::CH_RCURLY:  k = bbc_pkg::KIND_CURLY;
            default:             k = bbc_pkg::KIND_NONE;
        endcase
        return k;
    endfunction

    task automatic hold_error(bbc_pkg::status_t st, logic [bbc_pkg::CHAR_W-1:0] bad,
                              logic [bbc_pkg::CHAR_W-1:0] expd);
        err_st   = st;
        err_line = line_now;
        err_bad  = bad;
        err_expd = expd;
    endtask

    task automatic clear_scan();
        depth_now = 0;
        line_now  = bbc_pkg::LINE_ONE;
        err_st    = bbc_pkg::ST_SCAN;
        err_line  = bbc_pkg::LINE_ONE;
        err_bad   = bbc_pkg::CH_NULL;
        err_expd  = bbc_pkg::CH_SPACE;
    endtask

    // One item through the predictor. live: the block actually acted on it.
    task automatic scan_item(input logic op, input logic [bbc_pkg::CHAR_W-1:0] ch,
                             output scan_res_t r, output bit live);
        bbc_pkg::kind_t k;
        bit             is_open;
        live = (op == bbc_pkg::OP_EOF) || (err_st == bbc_pkg::ST_SCAN);
        if (op == bbc_pkg::OP_TEXT && err_st == bbc_pkg::ST_SCAN) begin
            k = bracket_kind(ch, is_open);
            if (k != bbc_pkg::KIND_NONE && is_open) begin
                if (depth_now >= DEPTH)
                    hold_error(bbc_pkg::ST_DEPTH, ch, bbc_pkg::CH_SPACE);
                else begin
                    open_stk[depth_now] = k;
                    depth_now++;
                end
            end else if (k != bbc_pkg::KIND_NONE) begin
                if (depth_now == 0)
                    hold_error(bbc_pkg::ST_CLOSE_NO_OPEN, ch, bbc_pkg::CH_SPACE);
                else if (open_stk[depth_now-1] != k)
                    hold_error(bbc_pkg::ST_MISMATCH, ch,
                               closing_char(open_stk[depth_now-1]));
                else
                    depth_now--;
            end else if (ch == bbc_pkg::CH_NEWLINE && line_now != bbc_pkg::LINE_MAX) begin
                line_now++;
            end
        end
        if (err_st != bbc_pkg::ST_SCAN) begin
            r.status = err_st;
            r.line   = err_line;
            r.bad    = err_bad;
            r.expd   = err_expd;
        end else begin
            if (op == bbc_pkg::OP_TEXT)
                r.status = bbc_pkg::ST_SCAN;
            else
                r.status = (depth_now == 0) ? bbc_pkg::ST_BALANCED : bbc_pkg::ST_UNCLOSED;
            r.line = line_now;
            r.bad  = bbc_pkg::CH_NULL;
            r.expd = bbc_pkg::CH_SPACE;
        end
        r.open_cnt = (depth_now > bbc_pkg::OPEN_MAX) ? bbc_pkg::OPEN_MAX
                                                     : bbc_pkg::OPEN_W'(depth_now);
        if (op == bbc_pkg::OP_EOF)
            clear_scan();
    endtask

    task automatic note_error(string what, longint got, longint want);
        err_count++;
        $display("MISMATCH at %0t: %s got %0h want %0h", $realtime, what, got, want);
    endtask

    // Present one item, hold it until taken, then queue what it should produce.
    task automatic send_item(input logic op, input logic [bbc_pkg::CHAR_W-1:0] ch,
                             input bit typed, input scan_res_t want);
        scan_res_t r;
        bit        live;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= ch;
        do @(posedge clk); while (!s_tready);
        scan_item(op, ch, r, live);
        verdict_q.push_back(typed ? want : r);
        items_sent++;
        if (live)
            live_items++;
    endtask

    task automatic idle_tx();
        int n;
        if (!quiet && tx_idle_on && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 16);
            s_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Hold off the sender until every owed result has come out.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (verdict_q.size() > 0);
    endtask

    function automatic dir_row_t mk(logic op, logic [bbc_pkg::CHAR_W-1:0] ch, int rep,
                                    bit typed, bbc_pkg::status_t st, int ln,
                                    logic [bbc_pkg::CHAR_W-1:0] bad,
                                    logic [bbc_pkg::CHAR_W-1:0] expd, int open_n);
        dir_row_t row;
        row.op            = op;
        row.ch            = ch;
        row.rep           = rep;
        row.typed         = typed;
        row.want.status   = st;
        row.want.line     = bbc_pkg::LINE_W'(ln);
        row.want.bad      = bad;
        row.want.expd     = expd;
        row.want.open_cnt = bbc_pkg::OPEN_W'(open_n);
        return row;
    endfunction

    task automatic load_rows();
        // end of file straight after reset, byte extremes, newline
        dir_rows.push_back(mk(bbc_pkg::OP_EOF, bbc_pkg::CH_NULL, 1, 1, bbc_pkg::ST_BALANCED,
                              1, bbc_pkg::CH_NULL, bbc_pkg::CH_SPACE, 0));
        dir_rows.push_back(mk(bbc_pkg::OP_TEXT, 8'h00, 1, 1, bbc_pkg::ST_SCAN,
                              1, bbc_pkg::CH_NULL, bbc_pkg::CH_SPACE, 0));
        dir_rows.push_back(mk(bbc_pkg::OP_TEXT, 8'hFF, 1, 1, bbc_pkg::ST_SCAN,
                              1, bbc_pkg::CH_NULL, bbc_pkg::CH_SPACE, 0));
        dir_rows.push_back(mk(bbc_pkg::OP_TEXT, bbc_pkg::CH_NEWLINE, 1, 1, bbc_pkg::ST_SCAN,
                              2, bbc_pkg::CH_NULL, bbc_pkg::CH_SPACE, 0));
        // every bracket opened and closed in order
        dir_rows.push_back(mk(bbc_pkg::OP_TEXT, bbc_pkg::CH_LPAREN, 1, 0, bbc_pkg::ST_SCAN,
                              0, bbc_pkg::CH_NULL, bbc_pkg::CH_SPACE, 0));
        dir_rows.push_back(mk(bbc_pkg::OP_TEXT, bbc_pkg::CH_LSQUARE, 1, 0, bbc_pkg::ST_SCAN,
                              0, bbc_pkg::CH_NULL, bbc_pkg::CH_SPACE, 0));
        dir_rows.push_back(mk(bbc_pkg::OP_TEXT, bbc_pkg::CH_LCURLY, 1, 0, bbc_pkg::ST_SCAN,
                              0, bbc_pkg::CH_NULL, bbc_pkg::CH_SPACE, 0));
        dir_rows.push_back(mk(bbc_pkg::OP_TEXT, bbc_pkg::CH_RCURLY, 1, 0, bbc_pkg::ST_SCAN,
                              0, bbc_pkg::CH_NULL, bbc_pkg::CH_SPACE, 0));
        dir_rows.push_back(mk(bbc_pkg::OP_TEXT, bbc_pkg::CH_RSQUARE, 1, 0, bbc_pkg::ST_SCAN,
                              0, bbc_pkg::CH_NULL, bbc_pkg::CH_SPACE, 0));
        dir_rows.push_back(mk(bbc_pkg::OP_TEXT, bbc_pkg::CH_RPAREN, 1, 0, bbc_pkg::ST_SCAN,
                              0, bbc_pkg::CH_NULL, bbc_pkg::CH_SPACE, 0));
        // close with nothing open, then the error holds through newline and open
        dir_rows.push_back(mk(bbc_pkg::OP_TEXT, bbc_pkg::CH_RPAREN, 1, 1,
                              bbc_pkg::ST_CLOSE_NO_OPEN, 2, bbc_pkg::CH_RPAREN,
                              bbc_pkg::CH_SPACE, 0));
        dir_rows.push_back(mk(bbc_pkg::OP_TEXT, bbc_pkg::CH_NEWLINE, 1, 1,
                              bbc_pkg::ST_CLOSE_NO_OPEN, 2, bbc_pkg::CH_RPAREN,
                              bbc_pkg::CH_SPACE, 0));
        dir_rows.push_back(mk(bbc_pkg::OP_TEXT, bbc_pkg::CH_LPAREN, 1, 1,
                              bbc_pkg::ST_CLOSE_NO_OPEN, 2, bbc_pkg::CH_RPAREN,
                              bbc_pkg::CH_SPACE, 0));
        dir_rows.push_back(mk(bbc_pkg::OP_EOF, bbc_pkg::CH_NULL, 1, 1,
                              bbc_pkg::ST_CLOSE_NO_OPEN, 2, bbc_pkg::CH_RPAREN,
                              bbc_pkg::CH_SPACE, 0));
        // mismatch: square closes a round
        dir_rows.push_back(mk(bbc_pkg::OP_TEXT, bbc_pkg::CH_LSQUARE, 1, 0, bbc_pkg::ST_SCAN,
                              0, bbc_pkg::CH_NULL, bbc_pkg::CH_SPACE, 0));
        dir_rows.push_back(mk(bbc_pkg::OP_TEXT, bbc_pkg::CH_LPAREN, 1, 0, bbc_pkg::ST_SCAN,
                              0, bbc_pkg::CH_NULL, bbc_pkg::CH_SPACE, 0));
        dir_rows.push_back(mk(bbc_pkg::OP_TEXT, bbc_pkg::CH_RSQUARE, 1, 1,
                              bbc_pkg::ST_MISMATCH, 1, bbc_pkg::CH_RSQUARE,
                              bbc_pkg::CH_RPAREN, 2));
        dir_rows.push_back(mk(bbc_pkg::OP_EOF, bbc_pkg::CH_NULL, 1, 1,
                              bbc_pkg::ST_MISMATCH, 1, bbc_pkg::CH_RSQUARE,
                              bbc_pkg::CH_RPAREN, 2));
        // fill the stack, overflow it, end of file with the ignored byte all ones
        dir_rows.push_back(mk(bbc_pkg::OP_TEXT, bbc_pkg::CH_LCURLY, DEPTH, 1,
                              bbc_pkg::ST_SCAN, 1, bbc_pkg::CH_NULL, bbc_pkg::CH_SPACE,
                              DEPTH));
        dir_rows.push_back(mk(bbc_pkg::OP_TEXT, bbc_pkg::CH_LPAREN, 1, 1,
                              bbc_pkg::ST_DEPTH, 1, bbc_pkg::CH_LPAREN, bbc_pkg::CH_SPACE,
                              DEPTH));
        dir_rows.push_back(mk(bbc_pkg::OP_EOF, 8'hFF, 1, 1,
                              bbc_pkg::ST_DEPTH, 1, bbc_pkg::CH_LPAREN, bbc_pkg::CH_SPACE,
                              DEPTH));
        // unclosed at end of file
        dir_rows.push_back(mk(bbc_pkg::OP_TEXT, bbc_pkg::CH_LCURLY, 1, 0, bbc_pkg::ST_SCAN,
                              0, bbc_pkg::CH_NULL, bbc_pkg::CH_SPACE, 0));
        dir_rows.push_back(mk(bbc_pkg::OP_TEXT, bbc_pkg::CH_NEWLINE, 3, 1, bbc_pkg::ST_SCAN,
                              4, bbc_pkg::CH_NULL, bbc_pkg::CH_SPACE, 1));
        dir_rows.push_back(mk(bbc_pkg::OP_EOF, bbc_pkg::CH_NULL, 1, 1, bbc_pkg::ST_UNCLOSED,
                              4, bbc_pkg::CH_NULL, bbc_pkg::CH_SPACE, 1));
        // mismatch: round closes a curly
        dir_rows.push_back(mk(bbc_pkg::OP_TEXT, bbc_pkg::CH_LCURLY, 1, 0, bbc_pkg::ST_SCAN,
                              0, bbc_pkg::CH_NULL, bbc_pkg::CH_SPACE, 0));
        dir_rows.push_back(mk(bbc_pkg::OP_TEXT, bbc_pkg::CH_RPAREN, 1, 1,
                              bbc_pkg::ST_MISMATCH, 1, bbc_pkg::CH_RPAREN,
                              bbc_pkg::CH_RCURLY, 1));
        dir_rows.push_back(mk(bbc_pkg::OP_EOF, bbc_pkg::CH_NULL, 1, 0, bbc_pkg::ST_SCAN,
                              0, bbc_pkg::CH_NULL, bbc_pkg::CH_SPACE, 0));
    endtask

    // Text that is not a bracket: mostly newlines, spaces and letters.
    function automatic logic [bbc_pkg::CHAR_W-1:0] filler();
        logic [bbc_pkg::CHAR_W-1:0] c;
        bit                         is_open;
        case ($urandom_range(0, 5))
            0, 1:    c = bbc_pkg::CH_NEWLINE;
            2:       c = bbc_pkg::CH_SPACE;
            3:       c = bbc_pkg::CHAR_W'($urandom_range(8'h61, 8'h7A));
            default: begin
                c = bbc_pkg::CHAR_W'($urandom);
                while (bracket_kind(c, is_open) != bbc_pkg::KIND_NONE)
                    c = bbc_pkg::CHAR_W'($urandom);
            end
        endcase
        return c;
    endfunction

    task automatic push_text(logic [bbc_pkg::CHAR_W-1:0] ch);
        text_item_t it;
        it.op = bbc_pkg::OP_TEXT;
        it.ch = ch;
        file_q.push_back(it);
    endtask

    // One random file. Most are well nested; some carry wrong or stray closers,
    // some nest past the stack limit, a few are raw noise.
    task automatic build_file();
        int             mode;
        int             len;
        int             maxd;
        int             err_pct;
        bbc_pkg::kind_t k;
        bbc_pkg::kind_t ks [$];
        text_item_t     eof_it;
        file_q.delete();
        mode = $urandom_range(0, 9);
        len  = $urandom_range(1, 48);
        if (mode == 9) begin
            repeat (len) push_text(bbc_pkg::CHAR_W'($urandom_range(0, 255)));
        end else begin
            if (mode == 8)
                maxd = DEPTH + 1;
            else
                maxd = ($urandom_range(0, 7) == 0) ? DEPTH : $urandom_range(1, 8);
            err_pct = (mode == 6 || mode == 7) ? 15 : 0;
            if (mode == 7 && $urandom_range(0, 2) == 0)
                push_text(closing_char(bbc_pkg::kind_t'($urandom_range(1, 3))));
            if (mode == 8) begin
                repeat ($urandom_range(DEPTH - 3, DEPTH + 2)) begin
                    k = bbc_pkg::kind_t'($urandom_range(1, 3));
                    ks.push_back(k);
                    push_text(opening_char(k));
                end
            end
            for (int i = 0; i < len; i++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: begin
                        if (ks.size() < maxd) begin
                            k = bbc_pkg::kind_t'($urandom_range(1, 3));
                            ks.push_back(k);
                            push_text(opening_char(k));
                        end else
                            push_text(filler());
                    end
                    3, 4, 5: begin
                        if (ks.size() > 0) begin
                            k = ks.pop_back();
                            if (err_pct > 0 && $urandom_range(0, 99) < err_pct)
                                k = bbc_pkg::kind_t'((k % 3) + 1);   // some other kind
                            push_text(closing_char(k));
                        end else
                            push_text(filler());
                    end
                    default: push_text(filler());
                endcase
            end
            if ($urandom_range(0, 3) != 0)
                while (ks.size() > 0)
                    push_text(closing_char(ks.pop_back()));
        end
        eof_it.op = bbc_pkg::OP_EOF;
        eof_it.ch = bbc_pkg::CHAR_W'($urandom_range(0, 255));
        file_q.push_back(eof_it);
    endtask

    task automatic check_result(logic [bbc_pkg::OUT_BYTES_W-1:0] word);
        scan_res_t got;
        scan_res_t want;
        got = scan_res_t'(word[bbc_pkg::OUT_W-1:0]);
        results_seen++;
        if (verdict_q.size() == 0) begin
            note_error("result with nothing owed, data", longint'(word), 0);
            return;
        end
        want = verdict_q.pop_front();
        status_seen[want.status]++;
        if (got.status !== want.status)
            note_error("status", longint'(got.status), longint'(want.status));
        if (got.line !== want.line)
            note_error("line_no", longint'(got.line), longint'(want.line));
        if (got.bad !== want.bad)
            note_error("bad_char", longint'(got.bad), longint'(want.bad));
        if (got.expd !== want.expd)
            note_error("expected_char", longint'(got.expd), longint'(want.expd));
        if (got.open_cnt !== want.open_cnt)
            note_error("open_count", longint'(got.open_cnt), longint'(want.open_cnt));
        if (word[bbc_pkg::OUT_BYTES_W-1:bbc_pkg::OUT_W] !== '0)
            note_error("pad bits", longint'(word[bbc_pkg::OUT_BYTES_W-1:bbc_pkg::OUT_W]), 0);
    endtask

    // Result side: take and check items, stall in random bursts.
    initial begin
        int  stall_left;
        int  cyc;
        bit  rx_idle_on;
        stall_left = 0;
        cyc = 0;
        rx_idle_on = 1'b1;
        forever begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                check_result(m_tdata);
            cyc++;
            if (cyc % 128 == 0)
                rx_idle_on = ($urandom_range(0, 3) != 0);
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!quiet && rx_idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 16) - 1;
                m_tready <= 1'b0;
            end else
                m_tready <= 1'b1;
        end
    end

    // Input side: reset, directed rows, then random files until enough items.
    initial begin
        scan_res_t none;
        int        dir_items;
        none = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        load_rows();
        foreach (dir_rows[i])
            for (int j = 0; j < dir_rows[i].rep; j++) begin
                send_item(dir_rows[i].op, dir_rows[i].ch,
                          dir_rows[i].typed && (j == dir_rows[i].rep - 1), dir_rows[i].want);
                idle_tx();
            end
        dir_items = items_sent;
        drain();

        while (items_sent < ITEMS) begin
            if (!quiet && $urandom_range(0, 15) == 0)
                drain();
            build_file();
            tx_idle_on = ($urandom_range(0, 3) != 0);
            files_sent++;
            foreach (file_q[i]) begin
                send_item(file_q[i].op, file_q[i].ch, 1'b0, none);
                quiet = (items_sent >= ITEMS - QUIET_TAIL);
                idle_tx();
            end
        end
        s_tvalid <= 1'b0;

        while (verdict_q.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("summary: %0d items (%0d directed, %0d acted on) in %0d random files, %0d checked",
                 items_sent, dir_items, live_items, files_sent, results_seen);
        $display("summary: scan %0d, balanced %0d, no-open %0d, mismatch %0d, unclosed %0d, depth %0d",
                 status_seen[bbc_pkg::ST_SCAN], status_seen[bbc_pkg::ST_BALANCED],
                 status_seen[bbc_pkg::ST_CLOSE_NO_OPEN], status_seen[bbc_pkg::ST_MISMATCH],
                 status_seen[bbc_pkg::ST_UNCLOSED], status_seen[bbc_pkg::ST_DEPTH]);
        if (err_count == 0 && verdict_q.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
